[rtl/mde_pkg.sv]
// Shared types and constants for the MIPS decode and execute pipeline.
`default_nettype none

package mde_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned REG_W       = 5;
  localparam int unsigned SHAMT_W     = 5;
  localparam int unsigned IN_TDATA_W  = 128;
  localparam int unsigned OUT_TDATA_W = 112;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTIU = 6'h0B;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  // R-type function codes
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [REG_W-1:0]  LINK_REG    = 5'd31;
  localparam logic [WORD_W-1:0] LINK_OFFSET = 32'd4;
  localparam logic [WORD_W-1:0] REGION_MASK = 32'hF000_0000;

  typedef enum logic [3:0] {
    ALU_ZERO  = 4'd0,
    ALU_ADD   = 4'd1,
    ALU_SUB   = 4'd2,
    ALU_AND   = 4'd3,
    ALU_OR    = 4'd4,
    ALU_NOR   = 4'd5,
    ALU_SLTU  = 4'd6,
    ALU_SLL   = 4'd7,
    ALU_SRL   = 4'd8,
    ALU_PASSB = 4'd9
  } alu_op_t;

  // Decoded instruction handed from decode to execute
  typedef struct packed {
    alu_op_t             alu_op;
    logic [WORD_W-1:0]   op_a;
    logic [WORD_W-1:0]   op_b;
    logic [SHAMT_W-1:0]  shamt;
    logic                br_eq;
    logic                br_ne;
    logic [WORD_W-1:0]   branch_target;
    logic [REG_W-1:0]    dest_reg;
    logic                reg_write;
    logic                mem_read;
    logic                mem_write;
    logic                from_memory;
    logic                jump_taken;
    logic [WORD_W-1:0]   jump_target;
  } dec_t;

  // Execute result, one per instruction
  typedef struct packed {
    logic [WORD_W-1:0]   jump_target;
    logic                jump_taken;
    logic                from_memory;
    logic                mem_write;
    logic                mem_read;
    logic                reg_write;
    logic [REG_W-1:0]    dest_reg;
    logic [WORD_W-1:0]   branch_target;
    logic                branch_taken;
    logic [WORD_W-1:0]   alu_result;
  } res_t;

endpackage

`default_nettype wire

[rtl/mips_decode_execute_unit_top.sv]
// Top level of the MIPS decode and execute pipeline with its output register.
//
// Usage: present one instruction per transfer on the in_ channel; in_tdata
// carries the instruction word, the rs and rt register values and next_pc.
// Each instruction yields exactly one transfer on the out_ channel with the
// ALU result, branch and jump outcome and all control flags.
//
// The result passes the decode register, the execute register and the output
// register before out_tvalid rises. Throughput: one instruction per cycle
// while out_tready stays high; every stage holds a valid bit and advances
// whenever the stage after it is empty or moving, so bubbles close up and
// in_tready stays high while any stage has room.
//
// Reset (rst_n low, synchronous) empties all three stages; no result is
// presented afterwards until a new instruction arrives.
//
// When the receiver holds out_tready low the result stays on out_tdata; the
// stages behind it keep filling, and in_tready falls once all three are full.
`default_nettype none

module mips_decode_execute_unit_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // [31:0] instr_word, [63:32] rs_value, [95:64] rt_value, [127:96] next_pc
  input  wire  [mde_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [31:0] alu_result, [32] branch_taken, [64:33] branch_target,
  // [69:65] dest_reg, [70] reg_write, [71] mem_read, [72] mem_write,
  // [73] from_memory, [74] jump_taken, [106:75] jump_target, [111:107] zero
  output logic [mde_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import mde_pkg::*;

  localparam int unsigned RES_W = $bits(res_t);

  logic   dec_valid;
  logic   dec_ready;
  dec_t   dec_data;
  logic   ex_valid;
  logic   ex_ready;
  res_t   ex_res;
  logic   out_valid_r;
  res_t   out_res_r;

  mde_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (in_tvalid),
    .s_ready    (in_tready),
    .instr_word (in_tdata[31:0]),
    .rs_value   (in_tdata[63:32]),
    .rt_value   (in_tdata[95:64]),
    .next_pc    (in_tdata[127:96]),
    .m_valid    (dec_valid),
    .m_ready    (dec_ready),
    .m_dec      (dec_data)
  );

  mde_execute u_execute (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (dec_valid),
    .s_ready (dec_ready),
    .s_dec   (dec_data),
    .m_valid (ex_valid),
    .m_ready (ex_ready),
    .m_res   (ex_res)
  );

  // Output register: hold the result until the receiver takes it
  assign ex_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ex_ready) begin
      out_valid_r <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_ready && ex_valid) begin
      out_res_r <= ex_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_res_r};

  // A load always writes back from memory
  a_load_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.mem_read |-> out_res_r.from_memory && out_res_r.reg_write)
    else $error("load result without memory writeback");

  // Stores and taken branches never write a register
  a_store_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.mem_write || out_res_r.branch_taken) |-> !out_res_r.reg_write)
    else $error("store or branch marked as register write");

  // No jump target is reported without a jump
  a_jump_target_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.jump_taken |-> out_res_r.jump_target == '0)
    else $error("jump target set without a jump");

  // A held execute result is not dropped while the output register is blocked
  a_ex_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ex_valid && !ex_ready |=> ex_valid)
    else $error("execute stage lost an instruction during stall");

endmodule

`default_nettype wire

[rtl/mde_decode.sv]
// Decode stage: control decode, operand selection, branch and jump targets.
`default_nettype none

module mde_decode (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            s_valid,
  output logic                           s_ready,
  input  wire  [mde_pkg::WORD_W-1:0]     instr_word,
  input  wire  [mde_pkg::WORD_W-1:0]     rs_value,
  input  wire  [mde_pkg::WORD_W-1:0]     rt_value,
  input  wire  [mde_pkg::WORD_W-1:0]     next_pc,
  output logic                           m_valid,
  input  wire                            m_ready,
  output mde_pkg::dec_t                  m_dec
);
  import mde_pkg::*;

  logic                valid_r;
  dec_t                dec_r;
  dec_t                dec_nxt;
  logic [5:0]          opcode;
  logic [5:0]          funct;
  logic [WORD_W-1:0]   simm;
  logic [WORD_W-1:0]   zimm;
  logic [WORD_W-1:0]   jt_region;

  assign opcode    = instr_word[31:26];
  assign funct     = instr_word[5:0];
  assign simm      = {{16{instr_word[15]}}, instr_word[15:0]};
  assign zimm      = {16'd0, instr_word[15:0]};
  assign jt_region = (next_pc & REGION_MASK) | {4'd0, instr_word[25:0], 2'b00};

  always_comb begin
    dec_nxt               = '0;
    dec_nxt.alu_op        = ALU_ZERO;
    dec_nxt.op_a          = rs_value;
    dec_nxt.op_b          = rt_value;
    dec_nxt.shamt         = instr_word[10:6];
    dec_nxt.branch_target = next_pc + {simm[WORD_W-3:0], 2'b00};
    case (opcode)
      OP_ADDIU: begin
        dec_nxt.alu_op = ALU_ADD;  dec_nxt.op_b = simm;
        dec_nxt.dest_reg = instr_word[20:16]; dec_nxt.reg_write = 1'b1;
      end
      OP_ANDI: begin
        dec_nxt.alu_op = ALU_AND;  dec_nxt.op_b = zimm;
        dec_nxt.dest_reg = instr_word[20:16]; dec_nxt.reg_write = 1'b1;
      end
      OP_ORI: begin
        dec_nxt.alu_op = ALU_OR;   dec_nxt.op_b = zimm;
        dec_nxt.dest_reg = instr_word[20:16]; dec_nxt.reg_write = 1'b1;
      end
      OP_SLTIU: begin
        dec_nxt.alu_op = ALU_SLTU; dec_nxt.op_b = simm;
        dec_nxt.dest_reg = instr_word[20:16]; dec_nxt.reg_write = 1'b1;
      end
      OP_LUI: begin
        dec_nxt.alu_op = ALU_PASSB; dec_nxt.op_b = {instr_word[15:0], 16'd0};
        dec_nxt.dest_reg = instr_word[20:16]; dec_nxt.reg_write = 1'b1;
      end
      OP_LW: begin
        dec_nxt.alu_op = ALU_ADD;  dec_nxt.op_b = simm;
        dec_nxt.dest_reg = instr_word[20:16]; dec_nxt.reg_write = 1'b1;
        dec_nxt.mem_read = 1'b1;   dec_nxt.from_memory = 1'b1;
      end
      OP_SW: begin
        dec_nxt.alu_op = ALU_ADD;  dec_nxt.op_b = simm;
        dec_nxt.dest_reg = instr_word[20:16]; dec_nxt.mem_write = 1'b1;
      end
      OP_BEQ: begin
        dec_nxt.dest_reg = instr_word[20:16]; dec_nxt.br_eq = 1'b1;
      end
      OP_BNE: begin
        dec_nxt.dest_reg = instr_word[20:16]; dec_nxt.br_ne = 1'b1;
      end
      OP_J: begin
        dec_nxt.jump_taken = 1'b1; dec_nxt.jump_target = jt_region;
      end
      OP_JAL: begin
        // link value is next_pc + 4, formed by the adder in execute
        dec_nxt.jump_taken = 1'b1; dec_nxt.jump_target = jt_region;
        dec_nxt.alu_op = ALU_ADD;  dec_nxt.op_a = next_pc; dec_nxt.op_b = LINK_OFFSET;
        dec_nxt.dest_reg = LINK_REG; dec_nxt.reg_write = 1'b1;
      end
      OP_RTYPE: begin
        dec_nxt.dest_reg = instr_word[15:11];
        case (funct)
          FN_ADDU: begin dec_nxt.alu_op = ALU_ADD;  dec_nxt.reg_write = 1'b1; end
          FN_SUBU: begin dec_nxt.alu_op = ALU_SUB;  dec_nxt.reg_write = 1'b1; end
          FN_AND:  begin dec_nxt.alu_op = ALU_AND;  dec_nxt.reg_write = 1'b1; end
          FN_OR:   begin dec_nxt.alu_op = ALU_OR;   dec_nxt.reg_write = 1'b1; end
          FN_NOR:  begin dec_nxt.alu_op = ALU_NOR;  dec_nxt.reg_write = 1'b1; end
          FN_SLTU: begin dec_nxt.alu_op = ALU_SLTU; dec_nxt.reg_write = 1'b1; end
          FN_SLL: begin
            // the all-zero word is the nop and must not write
            dec_nxt.alu_op = ALU_SLL; dec_nxt.reg_write = |instr_word;
          end
          FN_SRL:  begin dec_nxt.alu_op = ALU_SRL;  dec_nxt.reg_write = 1'b1; end
          FN_JR: begin
            dec_nxt.jump_taken = 1'b1; dec_nxt.jump_target = rs_value;
          end
          default: dec_nxt.dest_reg = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_dec   = dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/mde_execute.sv]
// Execute stage: ALU operation and branch condition.
`default_nettype none

module mde_execute (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             s_valid,
  output logic            s_ready,
  input  mde_pkg::dec_t   s_dec,
  output logic            m_valid,
  input  wire             m_ready,
  output mde_pkg::res_t   m_res
);
  import mde_pkg::*;

  logic                valid_r;
  res_t                res_r;
  res_t                res_nxt;
  logic [WORD_W-1:0]   alu_out;

  always_comb begin
    case (s_dec.alu_op)
      ALU_ADD:   alu_out = s_dec.op_a + s_dec.op_b;
      ALU_SUB:   alu_out = s_dec.op_a - s_dec.op_b;
      ALU_AND:   alu_out = s_dec.op_a & s_dec.op_b;
      ALU_OR:    alu_out = s_dec.op_a | s_dec.op_b;
      ALU_NOR:   alu_out = ~(s_dec.op_a | s_dec.op_b);
      ALU_SLTU:  alu_out = {{(WORD_W-1){1'b0}}, (s_dec.op_a < s_dec.op_b)};
      ALU_SLL:   alu_out = s_dec.op_b << s_dec.shamt;
      ALU_SRL:   alu_out = s_dec.op_b >> s_dec.shamt;
      ALU_PASSB: alu_out = s_dec.op_b;
      default:   alu_out = '0;
    endcase
  end

  always_comb begin
    res_nxt.alu_result    = alu_out;
    res_nxt.branch_taken  = (s_dec.br_eq && (s_dec.op_a == s_dec.op_b))
                         || (s_dec.br_ne && (s_dec.op_a != s_dec.op_b));
    res_nxt.branch_target = s_dec.branch_target;
    res_nxt.dest_reg      = s_dec.dest_reg;
    res_nxt.reg_write     = s_dec.reg_write;
    res_nxt.mem_read      = s_dec.mem_read;
    res_nxt.mem_write     = s_dec.mem_write;
    res_nxt.from_memory   = s_dec.from_memory;
    res_nxt.jump_taken    = s_dec.jump_taken;
    res_nxt.jump_target   = s_dec.jump_target;
  end

  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire
